// ===== design/rgb_euclidean_distance_sum_macros.svh =====
// ----------------------------------------------------------------------------
// RGB Euclidean distance sum: assertion macros
// Shared concurrent check forms, clocked on i_clk, quiet while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_EUCLIDEAN_DISTANCE_SUM_MACROS_SVH
`define RGB_EUCLIDEAN_DISTANCE_SUM_MACROS_SVH

// same-cycle implication
`define RGBEDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RGBEDS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rgbeds_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB Euclidean distance sum: package
// Widths, limits and the pipeline control word shared by all modules.
// ----------------------------------------------------------------------------
package rgbeds_pkg;

    localparam int SAMPLE_W = 24;                 // signed Q11.12 sample
    localparam int DIFF_W   = SAMPLE_W + 1;       // exact channel difference
    localparam int MAG_W    = SAMPLE_W;           // |difference| < 2^24
    localparam int SQ_W     = 2 * MAG_W;          // square, Q.24
    localparam int RAD_W    = SQ_W + 2;           // sum of three squares
    localparam int ROOT_W   = RAD_W / 2;          // one root bit per cell
    localparam int REM_W    = ROOT_W + 2;         // remainder <= 2 * root
    localparam int TOTAL_W  = 46;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam int IN_TDATA_W  = 6 * SAMPLE_W;
    localparam int OUT_TDATA_W = ((TOTAL_W + 7) / 8) * 8;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

endpackage

// ===== design/rgbeds_front.sv =====
// ----------------------------------------------------------------------------
// RGB Euclidean distance sum: front end
// Channel differences, squares and their sum over three register stages.
// ----------------------------------------------------------------------------
module rgbeds_front import rgbeds_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_ctl                i_ctl,
    input  logic [IN_TDATA_W-1:0] i_samples,  // fields as the slave tdata
    output t_ctl                o_ctl,
    output logic [RAD_W-1:0]    o_sum
);

    t_ctl                     r_ctl_d;
    t_ctl                     r_ctl_q;
    t_ctl                     r_ctl_s;
    logic signed [DIFF_W-1:0] r_diff [3];
    logic [SQ_W-1:0]          r_sq   [3];
    logic [RAD_W-1:0]         r_sum;

    logic signed [DIFF_W-1:0] w_diff [3];
    logic [MAG_W-1:0]         w_mag  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_diff[c] = DIFF_W'($signed(i_samples[c*SAMPLE_W +: SAMPLE_W]))
                      - DIFF_W'($signed(i_samples[(c+3)*SAMPLE_W +: SAMPLE_W]));
        end
    end

    always_comb begin
        logic [DIFF_W-1:0] neg;
        for (int c = 0; c < 3; c++) begin
            neg      = DIFF_W'(-r_diff[c]);
            w_mag[c] = r_diff[c][DIFF_W-1] ? neg[MAG_W-1:0]
                                           : r_diff[c][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_d <= '0;
            r_ctl_q <= '0;
            r_ctl_s <= '0;
        end else if (i_en) begin
            r_ctl_d <= i_ctl;
            r_ctl_q <= r_ctl_d;
            r_ctl_s <= r_ctl_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_diff[c] <= w_diff[c];
                r_sq[c]   <= w_mag[c] * w_mag[c];
            end
            r_sum <= RAD_W'(r_sq[0]) + RAD_W'(r_sq[1]) + RAD_W'(r_sq[2]);
        end
    end

    assign o_ctl = r_ctl_s;
    assign o_sum = r_sum;

endmodule

// ===== design/rgbeds_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// RGB Euclidean distance sum: square root cell
// One restoring root step: pulls two radicand bits, settles one root bit.
// ----------------------------------------------------------------------------
`include "rgb_euclidean_distance_sum_macros.svh"

module rgbeds_sqrt_cell import rgbeds_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_ctl              i_ctl,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [ROOT_W-1:0] i_root,
    input  logic [REM_W-1:0]  i_rem,
    output t_ctl              o_ctl,
    output logic [RAD_W-1:0]  o_rad,
    output logic [ROOT_W-1:0] o_root,
    output logic [REM_W-1:0]  o_rem
);

    t_ctl              r_ctl;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  r_rem;

    logic [REM_W+1:0]  w_pulled;
    logic [REM_W+1:0]  w_trial;
    logic [REM_W+1:0]  w_diff;
    logic              w_fits;

    assign w_pulled = {i_rem, i_rad[RAD_W-1 -: 2]};
    assign w_trial  = {{(REM_W-ROOT_W){1'b0}}, i_root, 2'b01};
    assign w_fits   = (w_pulled >= w_trial);
    assign w_diff   = w_pulled - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[RAD_W-3:0], 2'b00};
            r_root <= {i_root[ROOT_W-2:0], w_fits};
            r_rem  <= w_fits ? w_diff[REM_W-1:0] : w_pulled[REM_W-1:0];
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rad  = r_rad;
    assign o_root = r_root;
    assign o_rem  = r_rem;

    // partial remainder never exceeds twice the partial root
    `RGBEDS_ASSERT_IMP(a_rem_bound, r_ctl.valid, r_rem <= {1'b0, r_root, 1'b0}, "sqrt remainder out of range")

endmodule

// ===== design/rgbeds_accum.sv =====
// ----------------------------------------------------------------------------
// RGB Euclidean distance sum: accumulator
// Saturating running total, flag, and the result register on the last pixel.
// ----------------------------------------------------------------------------
`include "rgb_euclidean_distance_sum_macros.svh"

module rgbeds_accum import rgbeds_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    input  logic [ROOT_W-1:0]  i_dist,
    input  logic               i_out_ready,
    output logic               o_stall,
    output logic               o_out_valid,
    output logic [TOTAL_W-1:0] o_total,
    output logic               o_sat
);

    logic [TOTAL_W-1:0] r_total;
    logic               r_ovf;
    logic               r_out_valid;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_sat;

    logic [TOTAL_W:0]   w_sum;
    logic [TOTAL_W-1:0] n_total;
    logic               n_ovf;
    logic               w_take;

    // a last pixel waits while the previous result is still held
    assign o_stall = i_ctl.valid && i_ctl.last && r_out_valid && !i_out_ready;
    assign w_take  = i_ctl.valid && !o_stall;

    assign w_sum   = {1'b0, r_total} + (TOTAL_W+1)'(i_dist);
    assign n_total = w_sum[TOTAL_W] ? TOTAL_MAX : w_sum[TOTAL_W-1:0];
    assign n_ovf   = r_ovf | w_sum[TOTAL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                if (i_ctl.last) begin
                    r_total <= '0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_total <= n_total;
                    r_ovf   <= n_ovf;
                end
            end
            if (w_take && i_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_ctl.last) begin
            r_out_total <= n_total;
            r_out_sat   <= n_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_total     = r_out_total;
    assign o_sat       = r_out_sat;

    `RGBEDS_ASSERT_IMP(a_ovf_pins_max, r_ovf, r_total == TOTAL_MAX, "flag set but total not at maximum")
    `RGBEDS_ASSERT_NXT(a_last_clears, w_take && i_ctl.last, r_out_valid && r_total == '0 && !r_ovf, "last pixel did not emit and clear")
    `RGBEDS_ASSERT_IMP(a_stall_cause, o_stall, r_out_valid && i_ctl.valid && i_ctl.last, "stall without a held result")

endmodule

// ===== design/rgb_euclidean_distance_sum.sv =====
// ----------------------------------------------------------------------------
// RGB Euclidean distance sum: top level
// Per-pixel RGB distance between two images, summed over a frame.
//
//   channel   dir  handshake                  payload
//   s_axis    in   tvalid / tready            tdata: six samples, tlast: last pixel
//   m_axis    out  tvalid / tready            tdata: total, tuser: saturated
//
// One pixel pair per cycle while not stalled; a last pixel passes three front
// stages, one root cell per root bit and one accumulate stage to its result.
// The only stall: a last pixel reaching the accumulator while the previous
// total is still held in the output register; the whole chain then holds.
// Synchronous reset clears all valid bits, the running total and the flag.
// ----------------------------------------------------------------------------
module rgb_euclidean_distance_sum import rgbeds_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // first_red, first_green, first_blue, second_red, second_green, second_blue
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tlast,   // last_pixel
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // total_distance, then zero padding
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [0:0]             o_m_axis_tuser    // saturated
);

    logic              w_stall;
    logic              w_en;
    t_ctl              w_in_ctl;
    t_ctl              w_ctl  [ROOT_W+1];
    logic [RAD_W-1:0]  w_rad  [ROOT_W+1];
    logic [ROOT_W-1:0] w_root [ROOT_W+1];
    logic [REM_W-1:0]  w_rem  [ROOT_W+1];
    logic [TOTAL_W-1:0] w_total;
    logic              w_sat;

    assign w_en            = !w_stall;
    assign o_s_axis_tready = w_en;
    assign w_in_ctl.valid  = i_s_axis_tvalid;
    assign w_in_ctl.last   = i_s_axis_tlast;

    rgbeds_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_ctl     (w_in_ctl),
        .i_samples (i_s_axis_tdata),
        .o_ctl     (w_ctl[0]),
        .o_sum     (w_rad[0])
    );

    assign w_root[0] = '0;
    assign w_rem[0]  = '0;

    for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
        rgbeds_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctl   (w_ctl[g]),
            .i_rad   (w_rad[g]),
            .i_root  (w_root[g]),
            .i_rem   (w_rem[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_rad   (w_rad[g+1]),
            .o_root  (w_root[g+1]),
            .o_rem   (w_rem[g+1])
        );
    end

    rgbeds_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl[ROOT_W]),
        .i_dist      (w_root[ROOT_W]),
        .i_out_ready (i_m_axis_tready),
        .o_stall     (w_stall),
        .o_out_valid (o_m_axis_tvalid),
        .o_total     (w_total),
        .o_sat       (w_sat)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-TOTAL_W){1'b0}}, w_total};
    assign o_m_axis_tuser = w_sat;

endmodule

// ===== test/distance_sum_checker.sv =====
// ----------------------------------------------------------------------------
// RGB Euclidean distance sum: stream checker
// Watches both stream channels and keeps its own running frame total. Each
// pixel request taken in adds its floor-root distance to that total. A last
// pixel queues the expected frame total and saturation flag. Each total taken
// out is compared field by field against the oldest queued frame.
// ----------------------------------------------------------------------------
module distance_sum_checker import rgbeds_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_pixel_tvalid,
    input  logic                   i_pixel_tready,
    // first_red, first_green, first_blue, second_red, second_green, second_blue
    input  logic [IN_TDATA_W-1:0]  i_pixel_tdata,
    input  logic                   i_pixel_tlast,   // last_pixel
    input  logic                   i_sum_tvalid,
    input  logic                   i_sum_tready,
    // total_distance, then zero padding
    input  logic [OUT_TDATA_W-1:0] i_sum_tdata,
    input  logic [0:0]             i_sum_tuser,     // saturated
    output int                     o_failures,
    output int                     o_sums_pending,
    output int                     o_pixels,
    output int                     o_frames,
    output int                     o_saturated_frames
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               saturated;
    } frame_sum_t;

    logic [TOTAL_W-1:0] running_sum = '0;
    logic               sum_clipped = 1'b0;
    frame_sum_t         expected_sums[$];
    int                 failures   = 0;
    int                 pixels     = 0;
    int                 frames     = 0;
    int                 sat_frames = 0;

    function automatic logic [63:0] channel_square(input logic [SAMPLE_W-1:0] a,
                                                   input logic [SAMPLE_W-1:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        return d * d;
    endfunction

    // largest r with r*r <= x, one bit at a time from the top
    function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root[ROOT_W-1:0];
    endfunction

    function automatic void add_pixel(input logic [IN_TDATA_W-1:0] data, input logic last);
        logic [63:0] radicand;
        logic [63:0] grown;
        radicand = '0;
        for (int c = 0; c < 3; c++)
            radicand += channel_square(data[c*SAMPLE_W +: SAMPLE_W],
                                       data[(c+3)*SAMPLE_W +: SAMPLE_W]);
        grown = 64'(running_sum) + 64'(floor_sqrt(radicand));
        if (grown > 64'(TOTAL_MAX)) begin
            running_sum = TOTAL_MAX;
            sum_clipped = 1'b1;
        end else begin
            running_sum = grown[TOTAL_W-1:0];
        end
        if (last) begin
            expected_sums.push_back('{total: running_sum, saturated: sum_clipped});
            running_sum = '0;
            sum_clipped = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin
        frame_sum_t want;
        if (!i_rst_n) begin
            running_sum = '0;
            sum_clipped = 1'b0;
            expected_sums.delete();
        end else begin
            if (i_pixel_tvalid && i_pixel_tready) begin
                add_pixel(i_pixel_tdata, i_pixel_tlast);
                pixels++;
            end
            if (i_sum_tvalid && i_sum_tready) begin
                if (expected_sums.size() == 0) begin
                    $display("%0t: unexpected frame total %0h, saturated %0b",
                             $time, i_sum_tdata[TOTAL_W-1:0], i_sum_tuser[0]);
                    failures++;
                end else begin
                    want = expected_sums.pop_front();
                    if (i_sum_tdata[TOTAL_W-1:0] !== want.total) begin
                        $display("%0t: total_distance expected %0h, got %0h",
                                 $time, want.total, i_sum_tdata[TOTAL_W-1:0]);
                        failures++;
                    end
                    if (i_sum_tuser[0] !== want.saturated) begin
                        $display("%0t: saturated expected %0b, got %0b",
                                 $time, want.saturated, i_sum_tuser[0]);
                        failures++;
                    end
                    frames++;
                    if (want.saturated)
                        sat_frames++;
                end
            end
        end
        // published through nonblocking assignments so the top never races these
        o_failures         <= failures;
        o_sums_pending     <= expected_sums.size();
        o_pixels           <= pixels;
        o_frames           <= frames;
        o_saturated_frames <= sat_frames;
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// RGB Euclidean distance sum: testbench top
// Drives pixel-pair requests into the block and reads back frame totals with
// random gaps and stalls on both sides. Directed pixels cover extremes and
// root truncation. A random part follows, with a long output hold-off that
// backs the block up. All checking is left to the checker; this module only
// drives and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbeds_pkg::*;

    localparam int CYCLE_LIMIT      = 100_000;
    localparam int HOLD_OFF_CYCLES  = 400;
    localparam int DRAIN_CYCLES     = 40;

    localparam logic [SAMPLE_W-1:0] S_MAX  = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] S_MIN  = 24'h800000;
    localparam logic [SAMPLE_W-1:0] S_ZERO = 24'h000000;
    localparam logic [SAMPLE_W-1:0] S_NEG1 = 24'hFFFFFF;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   pixel_tvalid = 1'b0;
    logic                   pixel_tready;
    logic [IN_TDATA_W-1:0]  pixel_tdata  = '0;
    logic                   pixel_tlast  = 1'b0;
    logic                   sum_tvalid;
    logic                   sum_tready   = 1'b0;
    logic [OUT_TDATA_W-1:0] sum_tdata;
    logic [0:0]             sum_tuser;

    int failures;
    int sums_pending;
    int pixels;
    int frames;
    int saturated_frames;
    int cycle_count = 0;

    bit sender_gaps     = 1'b0;
    bit receiver_stalls = 1'b0;
    bit pressure_req    = 1'b0;
    bit pressure_done   = 1'b0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    rgb_euclidean_distance_sum dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (pixel_tvalid),
        .o_s_axis_tready (pixel_tready),
        .i_s_axis_tdata  (pixel_tdata),
        .i_s_axis_tlast  (pixel_tlast),
        .o_m_axis_tvalid (sum_tvalid),
        .i_m_axis_tready (sum_tready),
        .o_m_axis_tdata  (sum_tdata),
        .o_m_axis_tuser  (sum_tuser)
    );

    distance_sum_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_pixel_tvalid     (pixel_tvalid),
        .i_pixel_tready     (pixel_tready),
        .i_pixel_tdata      (pixel_tdata),
        .i_pixel_tlast      (pixel_tlast),
        .i_sum_tvalid       (sum_tvalid),
        .i_sum_tready       (sum_tready),
        .i_sum_tdata        (sum_tdata),
        .i_sum_tuser        (sum_tuser),
        .o_failures         (failures),
        .o_sums_pending     (sums_pending),
        .o_pixels           (pixels),
        .o_frames           (frames),
        .o_saturated_frames (saturated_frames)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        wait (rst_n);
        forever begin
            if (pressure_req && !pressure_done) begin
                sum_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                pressure_done = 1'b1;
            end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
                sum_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end else begin
                sum_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // offer one pixel request, maybe after a gap, and hold it until taken
    task automatic offer_pixel(input logic [SAMPLE_W-1:0] fr, fg, fb, sr, sg, sb,
                               input logic last);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            pixel_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        pixel_tvalid <= 1'b1;
        pixel_tdata  <= {sb, sg, sr, fb, fg, fr};
        pixel_tlast  <= last;
        @(posedge clk);
        while (!pixel_tready)
            @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 6))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SAMPLE_W'($urandom_range(0, 31));
            3:       return S_ZERO - SAMPLE_W'($urandom_range(1, 32));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic offer_random_pixel(input logic last);
        logic [SAMPLE_W-1:0] fs [3];
        logic [SAMPLE_W-1:0] ss [3];
        for (int c = 0; c < 3; c++) begin
            fs[c] = pick_sample();
            // a third of channels sit close to their partner
            if ($urandom_range(0, 2) == 0)
                ss[c] = fs[c] + SAMPLE_W'($urandom_range(0, 8)) - SAMPLE_W'(4);
            else
                ss[c] = pick_sample();
        end
        offer_pixel(fs[0], fs[1], fs[2], ss[0], ss[1], ss[2], last);
    endtask

    task automatic send_frames(input int n_pixels, input bit every_last);
        for (int k = 0; k < n_pixels; k++)
            offer_random_pixel(every_last || k == n_pixels - 1 || $urandom_range(0, 4) == 0);
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, sign of difference, single channels
        offer_pixel(S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b1);
        offer_pixel(S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_MIN, 1'b1);
        offer_pixel(S_MIN, S_MIN, S_MIN, S_MAX, S_MAX, S_MAX, 1'b1);
        offer_pixel(S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, 1'b1);
        offer_pixel(S_NEG1, S_NEG1, S_NEG1, S_NEG1, S_NEG1, S_NEG1, 1'b1);
        offer_pixel(S_MIN, S_ZERO, S_ZERO, S_MAX, S_ZERO, S_ZERO, 1'b0);
        offer_pixel(S_ZERO, S_MAX, S_ZERO, S_ZERO, S_MIN, S_ZERO, 1'b0);
        offer_pixel(S_ZERO, S_ZERO, S_MIN, S_ZERO, S_ZERO, S_MAX, 1'b1);
        // root truncation: sqrt 2, sqrt 3, exact 5, sqrt 26
        offer_pixel(24'd1, 24'd1, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b1);
        offer_pixel(24'd1, 24'd1, 24'd1, S_ZERO, S_ZERO, S_ZERO, 1'b1);
        offer_pixel(24'd3, S_ZERO, S_ZERO, S_ZERO, 24'd4, S_ZERO, 1'b1);
        offer_pixel(24'd3, 24'hFFFFFC, 24'd1, S_ZERO, S_ZERO, S_ZERO, 1'b1);
        // alternating bit patterns across all six fields
        offer_pixel(24'h555555, 24'hAAAAAA, 24'h0F0F0F, 24'hAAAAAA, 24'h555555, 24'hF0F0F0,
                    1'b1);

        // a zero-distance pixel inside a frame that the next pixel closes, then a single-pixel frame
        offer_pixel(S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b0);
        offer_pixel(24'd5, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b1);
        offer_pixel(24'd7, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b1);

        // random frames with gaps and stalls on both sides
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        send_frames(400, 1'b0);

        // long output hold-off while single-pixel frames keep coming
        sender_gaps  = 1'b0;
        pressure_req = 1'b1;
        send_frames(60, 1'b1);

        sender_gaps = 1'b1;
        send_frames(100, 1'b0);

        // closing stretch at full rate
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        send_frames(150, 1'b0);

        pixel_tvalid <= 1'b0;
        @(posedge clk);
        while (sums_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d pixel pairs in %0d frames checked, %0d of them saturated",
                 pixels, frames, saturated_frames);
        $display("included directed extremes and a %0d-cycle output hold-off",
                 HOLD_OFF_CYCLES);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
